FILE: sv/lps_pkg.sv
// lps_pkg.sv: shared types, constants and pattern tables of the led pattern sequencer
`timescale 1ns / 1ps

package lps_pkg;

   // configuration register indexes
   localparam logic CSR_FRAME_PERIOD   = 1'b0;
   localparam logic CSR_FRAMES_PER_RUN = 1'b1;

   // configuration reset values
   localparam logic [15:0] FRAME_PERIOD_RESET   = 16'd120;
   localparam logic [7:0]  FRAMES_PER_RUN_RESET = 8'd20;

   // transaction kinds
   localparam logic FUNC_TICK = 1'b0;
   localparam logic FUNC_KEY  = 1'b1;

   // mode key codes, ascii '1' to '9'
   localparam logic [7:0] MODE_NONE        = 8'h00;
   localparam logic [7:0] MODE_CHASE_RIGHT = 8'h31;
   localparam logic [7:0] MODE_CHASE_LEFT  = 8'h32;
   localparam logic [7:0] MODE_BOUNCE      = 8'h33;
   localparam logic [7:0] MODE_BLINK       = 8'h34;
   localparam logic [7:0] MODE_ALTERNATE   = 8'h35;
   localparam logic [7:0] MODE_COUNT       = 8'h36;
   localparam logic [7:0] MODE_EXPAND      = 8'h37;
   localparam logic [7:0] MODE_CONTRACT    = 8'h38;
   localparam logic [7:0] MODE_SPLIT       = 8'h39;

   // fixed frames
   localparam logic [7:0] PAT_ALL_ON   = 8'hFF;
   localparam logic [7:0] PAT_ALL_OFF  = 8'h00;
   localparam logic [7:0] PAT_EVEN_ON  = 8'h55;
   localparam logic [7:0] PAT_ODD_ON   = 8'hAA;

   typedef struct packed {
      logic       func;
      logic [7:0] key;
   } lps_req_type;

   typedef struct packed {
      logic [7:0] leds;
      logic       active;
   } lps_rsp_type;

   // one frame and the step state that follows it
   typedef struct packed {
      logic [7:0] pat;
      logic [7:0] step;
      logic       bounce_down;
   } lps_frame_type;

   // expand from centre to all on, then shrink back to the centre
   function automatic logic [7:0] expand_pat(input logic [2:0] idx);
      logic [7:0] p;
      case (idx)
         3'd0:    p = 8'h18;
         3'd1:    p = 8'h3C;
         3'd2:    p = 8'h7E;
         3'd3:    p = 8'hFF;
         3'd4:    p = 8'h7E;
         3'd5:    p = 8'h3C;
         3'd6:    p = 8'h18;
         default: p = 8'h00;
      endcase
      return p;
   endfunction

   // grow from the edges to all on, then contract back to the edges
   function automatic logic [7:0] contract_pat(input logic [2:0] idx);
      logic [7:0] p;
      case (idx)
         3'd0:    p = 8'h81;
         3'd1:    p = 8'hC3;
         3'd2:    p = 8'hE7;
         3'd3:    p = 8'hFF;
         3'd4:    p = 8'hE7;
         3'd5:    p = 8'hC3;
         3'd6:    p = 8'h81;
         default: p = 8'h00;
      endcase
      return p;
   endfunction

endpackage

FILE: sv/lps_frame_gen.sv
// lps_frame_gen.sv: frame pattern and next step for each animation mode
`timescale 1ns / 1ps

module lps_frame_gen (
   input  logic [7:0]             mode,
   input  logic [7:0]             step,
   input  logic                   bounce_down,
   output lps_pkg::lps_frame_type frame
);

   logic [2:0] s7;
   logic [1:0] q;
   logic       step_zero;
   logic       step_last;
   logic       bd_new;
   logic [7:0] step_inc;

   assign s7        = step[2:0];
   assign q         = step[1:0];
   assign step_zero = (step == 8'd0);
   assign step_last = (step == 8'd7);
   assign step_inc  = step + 8'd1;

   // bounce turns at both ends
   always_comb begin
      if (step_zero) begin
         bd_new = 1'b0;
      end else if (step_last) begin
         bd_new = 1'b1;
      end else begin
         bd_new = bounce_down;
      end
   end

   // per-mode frame and step advance
   always_comb begin
      frame.pat         = lps_pkg::PAT_ALL_OFF;
      frame.step        = step;
      frame.bounce_down = bounce_down;
      case (mode)
         lps_pkg::MODE_CHASE_RIGHT: begin
            frame.pat  = 8'd1 << s7;
            frame.step = (step_inc >= 8'd8) ? 8'd0 : step_inc;
         end
         lps_pkg::MODE_CHASE_LEFT: begin
            frame.pat  = 8'd1 << (3'd7 - s7);
            frame.step = (step_inc >= 8'd8) ? 8'd0 : step_inc;
         end
         lps_pkg::MODE_BOUNCE: begin
            frame.pat         = 8'd1 << s7;
            frame.bounce_down = bd_new;
            frame.step        = {5'd0, bd_new ? (s7 - 3'd1) : (s7 + 3'd1)};
         end
         lps_pkg::MODE_BLINK: begin
            frame.pat  = step_zero ? lps_pkg::PAT_ALL_ON : lps_pkg::PAT_ALL_OFF;
            frame.step = step_zero ? 8'd1 : 8'd0;
         end
         lps_pkg::MODE_ALTERNATE: begin
            frame.pat  = step_zero ? lps_pkg::PAT_EVEN_ON : lps_pkg::PAT_ODD_ON;
            frame.step = step_zero ? 8'd1 : 8'd0;
         end
         lps_pkg::MODE_COUNT: begin
            frame.pat  = step;
            frame.step = step_inc;
         end
         lps_pkg::MODE_EXPAND: begin
            frame.pat  = lps_pkg::expand_pat(s7);
            frame.step = (step_inc >= 8'd8) ? 8'd0 : step_inc;
         end
         lps_pkg::MODE_CONTRACT: begin
            frame.pat  = lps_pkg::contract_pat(s7);
            frame.step = (step_inc >= 8'd8) ? 8'd0 : step_inc;
         end
         lps_pkg::MODE_SPLIT: begin
            frame.pat  = (8'd1 << q) | (8'd1 << (3'd7 - {1'b0, q}));
            frame.step = (step_inc >= 8'd4) ? 8'd0 : step_inc;
         end
         default: begin
            frame.pat = lps_pkg::PAT_ALL_OFF;
         end
      endcase
   end

endmodule

FILE: sv/led_pattern_sequencer_unit.sv
// led_pattern_sequencer_unit.sv: top level of the eight-led animation sequencer
//
// req channel: one transaction is a millisecond tick (func 0) or a key press
// (func 1, key code in key). Keys '1' to '9' start an animation and give
// its first frame at once; the same key again is dropped; any other key
// clears the leds and gives one frame with active low. Ticks give a frame
// every frame_period_ms ticks while an animation runs.
// rsp channel: at most one frame per req transaction, in order.
// csr channel: index 0 frame_period_ms, index 1 frames_per_run (low byte);
// always ready; the user must write it only while the block is idle,
// as the block itself does not enforce this. A req passes the input
// register, then the result register, which drives rsp_valid.
// Throughput: one transaction per cycle while rsp is not stalled, set
// by the combinational state update between the two registers.
// A stalled rsp holds the result register; req keeps being taken while the
// pending transaction gives no frame, otherwise req_ready drops.
// Synchronous reset: idle, mode cleared, counters zero, bounce moving up,
// registers back to 120 ms and 20 frames.
`timescale 1ns / 1ps

module led_pattern_sequencer_unit (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   output logic                 req_ready,
   input  lps_pkg::lps_req_type req_data,
   output logic                 rsp_valid,
   input  logic                 rsp_ready,
   output lps_pkg::lps_rsp_type rsp_data,
   input  logic                 csr_valid,
   output logic                 csr_ready,
   input  logic                 csr_index,
   input  logic [15:0]          csr_wdata
);

   // configuration
   logic [15:0] frame_period_ff, frame_period_in;
   logic [7:0]  frames_per_run_ff, frames_per_run_in;

   // input register
   logic                 s1_valid_ff, s1_valid_in;
   lps_pkg::lps_req_type s1_req_ff, s1_req_in;

   // animation state
   logic        running_ff, running_in;
   logic [7:0]  mode_ff, mode_in;
   logic [7:0]  step_ff, step_in;
   logic [7:0]  frames_done_ff, frames_done_in;
   logic [15:0] ms_count_ff, ms_count_in;
   logic        bounce_down_ff, bounce_down_in;

   // result register
   logic                 rsp_valid_ff, rsp_valid_in;
   lps_pkg::lps_rsp_type rsp_data_ff, rsp_data_in;

   logic                   key_event;
   logic                   same_key;
   logic                   key_valid;
   logic [15:0]            period_eff;
   logic [7:0]             limit_eff;
   logic [16:0]            ms_inc;
   logic                   tick_fire;
   logic                   run_wrap;
   logic [7:0]             gen_mode;
   logic [7:0]             gen_step;
   lps_pkg::lps_frame_type frame;
   logic                   has_result;
   logic                   out_free;
   logic                   s1_adv;

   // decode of the held transaction
   assign key_event  = (s1_req_ff.func == lps_pkg::FUNC_KEY);
   assign same_key   = running_ff && (s1_req_ff.key == mode_ff);
   assign key_valid  = (s1_req_ff.key >= lps_pkg::MODE_CHASE_RIGHT) &&
                       (s1_req_ff.key <= lps_pkg::MODE_SPLIT);
   assign period_eff = (frame_period_ff == 16'd0) ? 16'd1 : frame_period_ff;
   assign limit_eff  = (frames_per_run_ff == 8'd0) ? 8'd1 : frames_per_run_ff;
   assign ms_inc     = {1'b0, ms_count_ff} + 17'd1;
   assign tick_fire  = (ms_inc >= {1'b0, period_eff});
   assign run_wrap   = (frames_done_ff >= limit_eff);
   assign gen_mode   = key_event ? s1_req_ff.key : mode_ff;
   assign gen_step   = (key_event || run_wrap) ? 8'd0 : step_ff;

   lps_frame_gen u_frame_gen (
      .mode        (gen_mode),
      .step        (gen_step),
      .bounce_down (bounce_down_ff),
      .frame       (frame)
   );

   // handshake between the stages
   assign has_result = key_event ? !same_key : (running_ff && tick_fire);
   assign out_free   = !rsp_valid_ff || rsp_ready;
   assign s1_adv     = s1_valid_ff && (!has_result || out_free);
   assign req_ready  = !s1_valid_ff || s1_adv;
   assign csr_ready  = 1'b1;
   assign rsp_valid  = rsp_valid_ff;
   assign rsp_data   = rsp_data_ff;

   // configuration writes
   always_comb begin
      frame_period_in   = frame_period_ff;
      frames_per_run_in = frames_per_run_ff;
      if (csr_valid) begin
         case (csr_index)
            lps_pkg::CSR_FRAME_PERIOD:   frame_period_in   = csr_wdata;
            lps_pkg::CSR_FRAMES_PER_RUN: frames_per_run_in = csr_wdata[7:0];
            default: begin
            end
         endcase
      end
   end

   // input register load
   always_comb begin
      s1_valid_in = s1_valid_ff;
      s1_req_in   = s1_req_ff;
      if (req_ready) begin
         s1_valid_in = req_valid;
         s1_req_in   = req_data;
      end
   end

   // state update and result for the held transaction
   always_comb begin
      running_in     = running_ff;
      mode_in        = mode_ff;
      step_in        = step_ff;
      frames_done_in = frames_done_ff;
      ms_count_in    = ms_count_ff;
      bounce_down_in = bounce_down_ff;
      rsp_data_in    = rsp_data_ff;
      rsp_valid_in   = rsp_valid_ff && !rsp_ready;
      if (s1_adv) begin
         if (key_event) begin
            if (!same_key) begin
               rsp_valid_in = 1'b1;
               ms_count_in  = 16'd0;
               if (key_valid) begin
                  running_in         = 1'b1;
                  mode_in            = s1_req_ff.key;
                  step_in            = frame.step;
                  bounce_down_in     = frame.bounce_down;
                  frames_done_in     = 8'd1;
                  rsp_data_in.leds   = frame.pat;
                  rsp_data_in.active = 1'b1;
               end else begin
                  running_in         = 1'b0;
                  mode_in            = lps_pkg::MODE_NONE;
                  step_in            = 8'd0;
                  frames_done_in     = 8'd0;
                  rsp_data_in.leds   = lps_pkg::PAT_ALL_OFF;
                  rsp_data_in.active = 1'b0;
               end
            end
         end else if (running_ff) begin
            if (!tick_fire) begin
               ms_count_in = ms_inc[15:0];
            end else begin
               rsp_valid_in       = 1'b1;
               ms_count_in        = 16'd0;
               step_in            = frame.step;
               bounce_down_in     = frame.bounce_down;
               frames_done_in     = (run_wrap ? 8'd0 : frames_done_ff) + 8'd1;
               rsp_data_in.leds   = frame.pat;
               rsp_data_in.active = 1'b1;
            end
         end
      end
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         frame_period_ff   <= lps_pkg::FRAME_PERIOD_RESET;
         frames_per_run_ff <= lps_pkg::FRAMES_PER_RUN_RESET;
         s1_valid_ff       <= 1'b0;
         running_ff        <= 1'b0;
         mode_ff           <= lps_pkg::MODE_NONE;
         step_ff           <= 8'd0;
         frames_done_ff    <= 8'd0;
         ms_count_ff       <= 16'd0;
         bounce_down_ff    <= 1'b0;
         rsp_valid_ff      <= 1'b0;
      end else begin
         frame_period_ff   <= frame_period_in;
         frames_per_run_ff <= frames_per_run_in;
         s1_valid_ff       <= s1_valid_in;
         running_ff        <= running_in;
         mode_ff           <= mode_in;
         step_ff           <= step_in;
         frames_done_ff    <= frames_done_in;
         ms_count_ff       <= ms_count_in;
         bounce_down_ff    <= bounce_down_in;
         rsp_valid_ff      <= rsp_valid_in;
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      s1_req_ff   <= s1_req_in;
      rsp_data_ff <= rsp_data_in;
   end

`ifndef SYNTH
   // a pending active frame means an animation is still running
   a_active_running: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && rsp_data_ff.active) |-> running_ff)
      else $error("active frame pending while idle");

   // a clear frame carries dark leds
   a_clear_dark: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && !rsp_data_ff.active) |-> (rsp_data_ff.leds == lps_pkg::PAT_ALL_OFF))
      else $error("clear frame with leds lit");

   // idle block holds no mode and no step
   a_idle_clean: assert property (@(posedge clock) disable iff (reset)
      !running_ff |-> (mode_ff == lps_pkg::MODE_NONE && step_ff == 8'd0))
      else $error("idle with stale animation state");
`endif

endmodule

FILE: bench/led_pattern_sequencer_unit_tb.sv
// led_pattern_sequencer_unit_tb.sv: self-checking bench of the led pattern sequencer
`timescale 1ns / 1ps

module led_pattern_sequencer_unit_tb;

   localparam int HALF_PERIOD  = 6;
   localparam int RESET_CYCLES = 4;
   localparam int DRAIN_SLACK  = 6;
   localparam int LONG_HOLD    = 80;

   // directed table rows: a request, or a register write between requests
   typedef enum logic [1:0] {ROW_REQ, ROW_CSR_WRITE} row_kind_type;

   typedef struct packed {
      row_kind_type kind;
      logic         sel;      // func for a request, register index for a write
      logic [15:0]  value;    // key in the low byte, or write data
      logic         typed;    // expectation given in the row
      logic         some;     // typed row gives a frame
      logic [7:0]   leds;
      logic         active;
   } stim_row_type;

   localparam int NUM_ROWS = 26;
   localparam stim_row_type STIM_TABLE [NUM_ROWS] = '{
      // idle block: tick dropped, any non-mode key clears
      '{ROW_REQ, lps_pkg::FUNC_TICK, 16'h00FF, 1'b1, 1'b0, 8'h00, 1'b0},
      '{ROW_REQ, lps_pkg::FUNC_KEY, 16'h0000, 1'b1, 1'b1, lps_pkg::PAT_ALL_OFF, 1'b0},
      '{ROW_REQ, lps_pkg::FUNC_KEY, 16'h00FF, 1'b1, 1'b1, lps_pkg::PAT_ALL_OFF, 1'b0},
      // first frame of every mode, and the same key dropped
      '{ROW_REQ, lps_pkg::FUNC_KEY, 16'(lps_pkg::MODE_CHASE_RIGHT), 1'b1, 1'b1, 8'h01, 1'b1},
      '{ROW_REQ, lps_pkg::FUNC_KEY, 16'(lps_pkg::MODE_CHASE_RIGHT), 1'b1, 1'b0, 8'h00, 1'b0},
      '{ROW_REQ, lps_pkg::FUNC_TICK, 16'h005A, 1'b0, 1'b0, 8'h00, 1'b0},
      '{ROW_REQ, lps_pkg::FUNC_KEY, 16'(lps_pkg::MODE_CHASE_LEFT), 1'b1, 1'b1, 8'h80, 1'b1},
      '{ROW_REQ, lps_pkg::FUNC_KEY, 16'(lps_pkg::MODE_BOUNCE), 1'b1, 1'b1, 8'h01, 1'b1},
      '{ROW_REQ, lps_pkg::FUNC_KEY, 16'(lps_pkg::MODE_BLINK), 1'b1, 1'b1,
        lps_pkg::PAT_ALL_ON, 1'b1},
      '{ROW_REQ, lps_pkg::FUNC_KEY, 16'(lps_pkg::MODE_ALTERNATE), 1'b1, 1'b1,
        lps_pkg::PAT_EVEN_ON, 1'b1},
      '{ROW_REQ, lps_pkg::FUNC_KEY, 16'(lps_pkg::MODE_COUNT), 1'b1, 1'b1, 8'h00, 1'b1},
      '{ROW_REQ, lps_pkg::FUNC_KEY, 16'(lps_pkg::MODE_EXPAND), 1'b1, 1'b1, 8'h18, 1'b1},
      '{ROW_REQ, lps_pkg::FUNC_KEY, 16'(lps_pkg::MODE_CONTRACT), 1'b1, 1'b1, 8'h81, 1'b1},
      '{ROW_REQ, lps_pkg::FUNC_KEY, 16'(lps_pkg::MODE_SPLIT), 1'b1, 1'b1, 8'h81, 1'b1},
      // keys outside the mode range: just outside it, and a high key after a restart
      '{ROW_REQ, lps_pkg::FUNC_KEY, 16'h0030, 1'b1, 1'b1, lps_pkg::PAT_ALL_OFF, 1'b0},
      '{ROW_REQ, lps_pkg::FUNC_KEY, 16'h003A, 1'b1, 1'b1, lps_pkg::PAT_ALL_OFF, 1'b0},
      '{ROW_REQ, lps_pkg::FUNC_KEY, 16'(lps_pkg::MODE_SPLIT), 1'b1, 1'b1, 8'h81, 1'b1},
      '{ROW_REQ, lps_pkg::FUNC_KEY, 16'h0080, 1'b1, 1'b1, lps_pkg::PAT_ALL_OFF, 1'b0},
      // zero period and zero run length behave as one
      '{ROW_CSR_WRITE, lps_pkg::CSR_FRAME_PERIOD, 16'h0000, 1'b0, 1'b0, 8'h00, 1'b0},
      '{ROW_CSR_WRITE, lps_pkg::CSR_FRAMES_PER_RUN, 16'h0000, 1'b0, 1'b0, 8'h00, 1'b0},
      '{ROW_REQ, lps_pkg::FUNC_KEY, 16'(lps_pkg::MODE_CHASE_RIGHT), 1'b1, 1'b1, 8'h01, 1'b1},
      '{ROW_REQ, lps_pkg::FUNC_TICK, 16'h00C3, 1'b0, 1'b0, 8'h00, 1'b0},
      '{ROW_REQ, lps_pkg::FUNC_TICK, 16'h0000, 1'b0, 1'b0, 8'h00, 1'b0},
      '{ROW_REQ, lps_pkg::FUNC_KEY, 16'(lps_pkg::MODE_BOUNCE), 1'b1, 1'b1, 8'h01, 1'b1},
      '{ROW_REQ, lps_pkg::FUNC_TICK, 16'h0011, 1'b0, 1'b0, 8'h00, 1'b0},
      '{ROW_REQ, lps_pkg::FUNC_TICK, 16'h00EE, 1'b0, 1'b0, 8'h00, 1'b0}
   };

   // random phases: register settings, traffic mix and handshake pressure
   typedef struct packed {
      logic [15:0] period;
      logic [15:0] frames;
      logic [7:0]  lead_key;
      logic [7:0]  key_pct;
      logic [7:0]  idle_pct;
      logic [7:0]  stall_pct;
      logic [15:0] items;
      logic [7:0]  drain_every;
      logic        long_hold;
   } phase_type;

   localparam int NUM_PHASES = 7;
   localparam phase_type PHASES [NUM_PHASES] = '{
      '{16'd1, 16'd255, lps_pkg::MODE_COUNT, 8'd0, 8'd0, 8'd0, 16'd300, 8'd0, 1'b0},
      '{16'd2, 16'hAB03, lps_pkg::MODE_BOUNCE, 8'd8, 8'd67, 8'd0, 16'd150, 8'd0, 1'b0},
      '{16'd1, 16'd7, lps_pkg::MODE_SPLIT, 8'd10, 8'd0, 8'd67, 16'd150, 8'd0, 1'b0},
      '{16'd3, 16'd20, lps_pkg::MODE_EXPAND, 8'd12, 8'd17, 8'd17, 16'd150, 8'd0, 1'b0},
      '{16'd1, 16'd5, lps_pkg::MODE_BOUNCE, 8'd60, 8'd0, 8'd0, 16'd120, 8'd12, 1'b1},
      '{16'hFFFF, 16'd1, lps_pkg::MODE_CHASE_LEFT, 8'd0, 8'd0, 8'd0, 16'd50, 8'd0, 1'b0},
      '{16'd4, 16'd2, lps_pkg::MODE_ALTERNATE, 8'd15, 8'd0, 8'd0, 16'd100, 8'd0, 1'b0}
   };

   localparam logic [7:0] EXPAND_FRAMES [8] =
      '{8'h18, 8'h3C, 8'h7E, 8'hFF, 8'h7E, 8'h3C, 8'h18, 8'h00};
   localparam logic [7:0] CONTRACT_FRAMES [8] =
      '{8'h81, 8'hC3, 8'hE7, 8'hFF, 8'hE7, 8'hC3, 8'h81, 8'h00};

   logic                 clock = 1'b0;
   logic                 reset = 1'b1;
   logic                 req_valid = 1'b0;
   logic                 req_ready;
   lps_pkg::lps_req_type req_data = '0;
   logic                 rsp_valid;
   logic                 rsp_ready = 1'b0;
   lps_pkg::lps_rsp_type rsp_data;
   logic                 csr_valid = 1'b0;
   logic                 csr_ready;
   logic                 csr_index = 1'b0;
   logic [15:0]          csr_wdata = '0;

   // sequencer model state and registers
   logic        run_on = 1'b0;
   logic [7:0]  mode_code = lps_pkg::MODE_NONE;
   logic [7:0]  step_idx = '0;
   logic [7:0]  frame_count = '0;
   logic [15:0] tick_count = '0;
   logic        bounce_dn = 1'b0;
   logic [15:0] cfg_period = lps_pkg::FRAME_PERIOD_RESET;
   logic [7:0]  cfg_frames = lps_pkg::FRAMES_PER_RUN_RESET;

   lps_pkg::lps_rsp_type frame_queue [$];
   lps_pkg::lps_rsp_type due_frame;
   int                   error_count = 0;
   int                   req_idle_pct = 0;
   int                   rsp_stall_pct = 0;
   int                   hold_left = 0;
   logic                 hold_req = 1'b0;
   logic                 hold_ack = 1'b0;

   led_pattern_sequencer_unit i_dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   // clock
   always begin
      #HALF_PERIOD clock = 1'b1;
      #HALF_PERIOD clock = 1'b0;
   end

   // step counter that wraps to zero at the limit
   function automatic logic [7:0] wrapped_step(input logic [7:0] s, input logic [7:0] lim);
      logic [7:0] n;
      n = s + 8'd1;
      return (n >= lim) ? 8'd0 : n;
   endfunction

   // current frame of the running mode, then move the step on
   function automatic logic [7:0] step_pattern();
      logic [7:0] s;
      logic [2:0] s7;
      logic [1:0] q;
      logic [7:0] pat;
      s = step_idx;
      s7 = s[2:0];
      q = s[1:0];
      pat = lps_pkg::PAT_ALL_OFF;
      case (mode_code)
         lps_pkg::MODE_CHASE_RIGHT: begin
            pat = 8'h01 << s7;
            step_idx = wrapped_step(s, 8'd8);
         end
         lps_pkg::MODE_CHASE_LEFT: begin
            pat = 8'h80 >> s7;
            step_idx = wrapped_step(s, 8'd8);
         end
         lps_pkg::MODE_BOUNCE: begin
            // direction turns at both ends and survives a restart
            if (s == 8'd0)
               bounce_dn = 1'b0;
            else if (s == 8'd7)
               bounce_dn = 1'b1;
            pat = 8'h01 << s7;
            step_idx = {5'd0, bounce_dn ? s7 - 3'd1 : s7 + 3'd1};
         end
         lps_pkg::MODE_BLINK: begin
            pat = (s == 8'd0) ? lps_pkg::PAT_ALL_ON : lps_pkg::PAT_ALL_OFF;
            step_idx = (s == 8'd0) ? 8'd1 : 8'd0;
         end
         lps_pkg::MODE_ALTERNATE: begin
            pat = (s == 8'd0) ? lps_pkg::PAT_EVEN_ON : lps_pkg::PAT_ODD_ON;
            step_idx = (s == 8'd0) ? 8'd1 : 8'd0;
         end
         lps_pkg::MODE_COUNT: begin
            pat = s;
            step_idx = s + 8'd1;
         end
         lps_pkg::MODE_EXPAND: begin
            pat = EXPAND_FRAMES[s7];
            step_idx = wrapped_step(s, 8'd8);
         end
         lps_pkg::MODE_CONTRACT: begin
            pat = CONTRACT_FRAMES[s7];
            step_idx = wrapped_step(s, 8'd8);
         end
         lps_pkg::MODE_SPLIT: begin
            pat = (8'h01 << q) | (8'h80 >> q);
            step_idx = wrapped_step(s, 8'd4);
         end
         default: pat = lps_pkg::PAT_ALL_OFF;
      endcase
      frame_count = frame_count + 8'd1;
      return pat;
   endfunction

   // frame caused by one transaction, if any
   function automatic bit predict_frame(input lps_pkg::lps_req_type r,
                                        output lps_pkg::lps_rsp_type f);
      logic [16:0] c;
      logic [15:0] per;
      logic [7:0]  lim;
      f = '0;
      if (r.func == lps_pkg::FUNC_KEY) begin
         if (run_on && r.key == mode_code)
            return 1'b0;
         step_idx = '0;
         frame_count = '0;
         tick_count = '0;
         if (r.key >= lps_pkg::MODE_CHASE_RIGHT && r.key <= lps_pkg::MODE_SPLIT) begin
            run_on = 1'b1;
            mode_code = r.key;
            f.leds = step_pattern();
            f.active = 1'b1;
         end else begin
            run_on = 1'b0;
            mode_code = lps_pkg::MODE_NONE;
            f.leds = lps_pkg::PAT_ALL_OFF;
            f.active = 1'b0;
         end
         return 1'b1;
      end
      if (!run_on)
         return 1'b0;
      per = (cfg_period == 16'd0) ? 16'd1 : cfg_period;
      lim = (cfg_frames == 8'd0) ? 8'd1 : cfg_frames;
      c = {1'b0, tick_count} + 17'd1;
      if (c < {1'b0, per}) begin
         tick_count = c[15:0];
         return 1'b0;
      end
      tick_count = '0;
      if (frame_count >= lim) begin
         step_idx = '0;
         frame_count = '0;
      end
      f.leds = step_pattern();
      f.active = 1'b1;
      return 1'b1;
   endfunction

   // offer one transaction, record the expected frame when it is taken
   task automatic send_item(input logic f, input logic [7:0] k, input logic typed,
                            input logic some, input lps_pkg::lps_rsp_type typed_frame);
      lps_pkg::lps_req_type r;
      lps_pkg::lps_rsp_type p;
      bit                   got;
      while ($urandom_range(99) < req_idle_pct) begin
         req_valid = 1'b0;
         @(negedge clock);
      end
      r.func = f;
      r.key = k;
      req_valid = 1'b1;
      req_data = r;
      forever begin
         @(posedge clock);
         if (req_ready)
            break;
      end
      got = predict_frame(r, p);
      if (typed) begin
         if (some)
            frame_queue.push_back(typed_frame);
      end else if (got) begin
         frame_queue.push_back(p);
      end
      @(negedge clock);
   endtask

   // stop offering and wait until every frame is back and the pipe is empty
   task automatic wait_drained();
      req_valid = 1'b0;
      while (frame_queue.size() != 0)
         @(negedge clock);
      repeat (DRAIN_SLACK) @(negedge clock);
   endtask

   task automatic write_csr(input logic idx, input logic [15:0] val);
      csr_valid = 1'b1;
      csr_index = idx;
      csr_wdata = val;
      forever begin
         @(posedge clock);
         if (csr_ready)
            break;
      end
      if (idx == lps_pkg::CSR_FRAME_PERIOD)
         cfg_period = val;
      else
         cfg_frames = val[7:0];
      @(negedge clock);
      csr_valid = 1'b0;
   endtask

   // result receiver: random stalls, plus a long hold on request
   always @(negedge clock) begin
      if (hold_req != hold_ack) begin
         hold_ack = hold_req;
         hold_left = LONG_HOLD;
      end
      if (hold_left > 0) begin
         rsp_ready = 1'b0;
         hold_left--;
      end else begin
         rsp_ready = ($urandom_range(99) >= rsp_stall_pct);
      end
   end

   // frame checker
   always @(posedge clock) begin
      if (!reset && rsp_valid && rsp_ready) begin
         if (frame_queue.size() == 0) begin
            $display("%0t: frame with none expected, got leds %02h active %0d",
                     $time, rsp_data.leds, rsp_data.active);
            error_count++;
         end else begin
            due_frame = frame_queue.pop_front();
            if (rsp_data.leds !== due_frame.leds) begin
               $display("%0t: leds mismatch, expected %02h, got %02h",
                        $time, due_frame.leds, rsp_data.leds);
               error_count++;
            end
            if (rsp_data.active !== due_frame.active) begin
               $display("%0t: active mismatch, expected %0d, got %0d",
                        $time, due_frame.active, rsp_data.active);
               error_count++;
            end
         end
      end
   end

   // stimulus
   initial begin
      stim_row_type         row;
      phase_type            ph;
      lps_pkg::lps_rsp_type typed_frame;
      logic [7:0]           k;
      logic                 f;
      repeat (RESET_CYCLES) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      // directed table
      foreach (STIM_TABLE[i]) begin
         row = STIM_TABLE[i];
         if (row.kind == ROW_CSR_WRITE) begin
            wait_drained();
            write_csr(row.sel, row.value);
         end else begin
            typed_frame.leds = row.leds;
            typed_frame.active = row.active;
            send_item(row.sel, row.value[7:0], row.typed, row.some, typed_frame);
         end
      end

      // random phases
      foreach (PHASES[n]) begin
         ph = PHASES[n];
         wait_drained();
         write_csr(lps_pkg::CSR_FRAME_PERIOD, ph.period);
         write_csr(lps_pkg::CSR_FRAMES_PER_RUN, ph.frames);
         req_idle_pct = ph.idle_pct;
         rsp_stall_pct = ph.stall_pct;
         if (ph.long_hold)
            hold_req = ~hold_req;
         send_item(lps_pkg::FUNC_KEY, ph.lead_key, 1'b0, 1'b0, '0);
         for (int j = 0; j < ph.items; j++) begin
            if ($urandom_range(99) < ph.key_pct) begin
               f = lps_pkg::FUNC_KEY;
               if ($urandom_range(9) < 8)
                  k = lps_pkg::MODE_CHASE_RIGHT + 8'($urandom_range(8));
               else
                  k = 8'($urandom_range(255));
            end else begin
               f = lps_pkg::FUNC_TICK;
               k = 8'($urandom_range(255));
            end
            send_item(f, k, 1'b0, 1'b0, '0);
            // sender pause until the block has handed back everything
            if (ph.drain_every != 0 && (j % ph.drain_every) == ph.drain_every - 1)
               wait_drained();
         end
      end

      wait_drained();
      if (error_count == 0)
         $display("led_pattern_sequencer_unit_tb OK");
      else
         $display("led_pattern_sequencer_unit_tb NOT OK");
      $finish;
   end

   // watchdog
   initial begin
      #20_000_000;
      $display("led_pattern_sequencer_unit_tb NOT OK");
      $finish;
   end

endmodule

FILE: led_pattern_sequencer_unit.f
sv/lps_pkg.sv
sv/lps_frame_gen.sv
sv/led_pattern_sequencer_unit.sv
bench/led_pattern_sequencer_unit_tb.sv
